@@ design/apl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apl_pkg - shared types and constants of the audio peak limiter
// Field widths, register indexes and reset values, the frame and result beat
// types, and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package apl_pkg;

	localparam int NUM_LANES        = 8;
	localparam int SMP_W            = 24;
	localparam int ENV_W            = 23;
	localparam int COEF_W           = 16;
	localparam int GAIN_W           = 24;
	localparam int CHCFG_W          = 4;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_W            = 23;
	localparam int DEF_MAX_CHANNELS = 8;
	localparam int DIV_STEPS        = ENV_W;
	localparam int PROD_ENV_W       = COEF_W + ENV_W;
	localparam int PROD_OUT_W       = 2 * SMP_W;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 2'd3;

	localparam logic [ENV_W-1:0]   THRESHOLD_RST = 23'd4204642;
	localparam logic [COEF_W-1:0]  ATTACK_RST    = 16'd64187;
	localparam logic [COEF_W-1:0]  RELEASE_RST   = 16'd65513;
	localparam logic [CHCFG_W-1:0] CHANNELS_RST  = 4'd2;

	localparam logic [ENV_W-1:0]  ENV_MAX    = 23'h7FFFFF;
	localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'h800000;

	typedef logic signed [SMP_W-1:0] sample_t;
	typedef logic [ENV_W-1:0]        env_t;
	typedef logic [GAIN_W-1:0]       gain_t;
	typedef logic [NUM_LANES-1:0][SMP_W-1:0] lane_vec_t;

	typedef struct packed {
		sample_t    sample_0;
		sample_t    sample_1;
		sample_t    sample_2;
		sample_t    sample_3;
		sample_t    sample_4;
		sample_t    sample_5;
		sample_t    sample_6;
		sample_t    sample_7;
		logic       block_start;
	} frame_t;

	typedef struct packed {
		sample_t    out_0;
		sample_t    out_1;
		sample_t    out_2;
		sample_t    out_3;
		sample_t    out_4;
		sample_t    out_5;
		sample_t    out_6;
		sample_t    out_7;
		gain_t      applied_gain;
		env_t       peak_envelope;
	} result_t;

	typedef struct packed {
		logic capture;
		logic env_a;
		logic env_b;
		logic gain_eval;
		logic div_start;
		logic set_unity;
		logic take_quot;
		logic out_mul;
		logic publish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic last_ch;
		logic need_div;
		logic div_busy;
		logic div_done;
	} ctrl_sts_t;

	function automatic lane_vec_t frame_lanes(input frame_t f);
		lane_vec_t v;
		v[0] = f.sample_0;
		v[1] = f.sample_1;
		v[2] = f.sample_2;
		v[3] = f.sample_3;
		v[4] = f.sample_4;
		v[5] = f.sample_5;
		v[6] = f.sample_6;
		v[7] = f.sample_7;
		return v;
	endfunction

	function automatic result_t pack_result(input lane_vec_t v, input gain_t g, input env_t p);
		result_t r;
		r.out_0         = v[0];
		r.out_1         = v[1];
		r.out_2         = v[2];
		r.out_3         = v[3];
		r.out_4         = v[4];
		r.out_5         = v[5];
		r.out_6         = v[6];
		r.out_7         = v[7];
		r.applied_gain  = g;
		r.peak_envelope = p;
		return r;
	endfunction

endpackage

@@ design/apl_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apl_div - restoring divider for the limiter gain
// Computes floor(dividend * 2^23 / divisor), one quotient bit per cycle.
// The dividend is below the divisor, so the quotient fits in 23 bits.
// ----------------------------------------------------------------------------
module apl_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  apl_pkg::env_t           dividend,
	input  apl_pkg::env_t           divisor,
	output logic                    busy,
	output logic                    done,
	output apl_pkg::env_t           quotient
);

	localparam int CNT_W = $clog2(apl_pkg::DIV_STEPS);

	logic                     busy_q;
	logic                     done_q;
	logic [CNT_W-1:0]         cnt_q;
	apl_pkg::env_t            rem_q;
	apl_pkg::env_t            dvs_q;
	apl_pkg::env_t            quo_q;
	logic [apl_pkg::ENV_W:0]  rem_shift;
	logic [apl_pkg::ENV_W:0]  rem_diff;
	logic                     fits;

	assign rem_shift = {rem_q, 1'b0};
	assign rem_diff  = rem_shift - {1'b0, dvs_q};
	assign fits      = rem_shift >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(apl_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[apl_pkg::ENV_W-1:0] : rem_shift[apl_pkg::ENV_W-1:0];
			quo_q <= {quo_q[apl_pkg::ENV_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ design/apl_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apl_dp - limiter datapath
// Configuration registers, channel envelopes, the shared envelope and output
// multipliers, the gain divider and the result register.
// ----------------------------------------------------------------------------
module apl_dp #(
	parameter int MAX_CHANNELS = apl_pkg::DEF_MAX_CHANNELS,
	parameter int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [apl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [apl_pkg::CFG_W-1:0]       cfg_data,
	input  apl_pkg::frame_t                 frame,
	input  logic [CH_W-1:0]                 ch,
	input  apl_pkg::ctrl_cmd_t              cmd,
	output apl_pkg::ctrl_sts_t              sts,
	output apl_pkg::result_t                result
);

	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

	apl_pkg::env_t                   threshold_q;
	logic [apl_pkg::COEF_W-1:0]      attack_q;
	logic [apl_pkg::COEF_W-1:0]      release_q;
	logic [apl_pkg::CHCFG_W-1:0]     channels_q;

	apl_pkg::frame_t                 frame_q;
	apl_pkg::env_t                   env_q [MAX_CHANNELS];
	apl_pkg::env_t                   combined_q;
	apl_pkg::env_t                   peak_q;
	apl_pkg::gain_t                  gain_q;
	apl_pkg::sample_t                res_q [MAX_CHANNELS];
	apl_pkg::result_t                result_q;

	apl_pkg::env_t                   mag_s1;
	apl_pkg::env_t                   diff_s1;
	logic                            rise_s1;
	logic [apl_pkg::COEF_W-1:0]      coef_s1;

	logic [CNT_W-1:0]                n_ch;
	apl_pkg::lane_vec_t              lanes;
	apl_pkg::lane_vec_t              outs_all;
	apl_pkg::sample_t                smp [MAX_CHANNELS];
	apl_pkg::sample_t                sel_smp;
	logic [apl_pkg::SMP_W-1:0]       abs_smp;
	apl_pkg::env_t                   mag_sat;
	apl_pkg::env_t                   env_cur;
	logic                            rise;
	logic [apl_pkg::PROD_ENV_W-1:0]  prod_env;
	apl_pkg::env_t                   corr;
	apl_pkg::env_t                   env_new;
	logic [apl_pkg::PROD_OUT_W-1:0]  prod_out;
	logic [apl_pkg::SMP_W-1:0]       scaled;
	apl_pkg::sample_t                res_val;
	apl_pkg::env_t                   quot;
	logic                            div_busy;
	logic                            div_done;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= apl_pkg::THRESHOLD_RST;
			attack_q    <= apl_pkg::ATTACK_RST;
			release_q   <= apl_pkg::RELEASE_RST;
			channels_q  <= apl_pkg::CHANNELS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				apl_pkg::REG_THRESHOLD: threshold_q <= cfg_data[apl_pkg::ENV_W-1:0];
				apl_pkg::REG_ATTACK:    attack_q    <= cfg_data[apl_pkg::COEF_W-1:0];
				apl_pkg::REG_RELEASE:   release_q   <= cfg_data[apl_pkg::COEF_W-1:0];
				apl_pkg::REG_CHANNELS:  channels_q  <= cfg_data[apl_pkg::CHCFG_W-1:0];
			endcase
		end
	end

	// A channel count above the lane count acts as the lane count.
	assign n_ch = (channels_q > apl_pkg::CHCFG_W'(MAX_CHANNELS)) ?
		CNT_W'(MAX_CHANNELS) : channels_q[CNT_W-1:0];

	assign lanes = apl_pkg::frame_lanes(frame_q);

	for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_smp
		assign smp[g] = lanes[g];
	end

	for (genvar g = 0; g < apl_pkg::NUM_LANES; g++) begin : g_outs
		if (g < MAX_CHANNELS) begin : g_used
			assign outs_all[g] = res_q[g];
		end else begin : g_unused
			assign outs_all[g] = '0;
		end
	end

	// Magnitude of the selected sample; only -1.0 sets the top bit, and the
	// envelope path saturates it to full scale.
	assign sel_smp = smp[ch];
	assign abs_smp = sel_smp[apl_pkg::SMP_W-1] ? apl_pkg::SMP_W'(-sel_smp) : sel_smp;
	assign mag_sat = abs_smp[apl_pkg::SMP_W-1] ? apl_pkg::ENV_MAX : abs_smp[apl_pkg::ENV_W-1:0];

	assign env_cur = env_q[ch];
	assign rise    = env_cur < mag_sat;

	// The correction is truncated toward the magnitude.
	assign prod_env = apl_pkg::PROD_ENV_W'(coef_s1) * apl_pkg::PROD_ENV_W'(diff_s1);
	assign corr     = prod_env[apl_pkg::PROD_ENV_W-1:apl_pkg::COEF_W];
	assign env_new  = rise_s1 ? (mag_s1 - corr) : (mag_s1 + corr);

	assign prod_out = apl_pkg::PROD_OUT_W'(abs_smp) * apl_pkg::PROD_OUT_W'(gain_q);
	assign scaled   = prod_out[apl_pkg::ENV_W+apl_pkg::SMP_W-1:apl_pkg::ENV_W];
	assign res_val  = sel_smp[apl_pkg::SMP_W-1] ? apl_pkg::SMP_W'(-scaled) : scaled;

	// Envelope state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				env_q[i] <= '0;
			end
			combined_q <= '0;
		end else begin
			if (cmd.capture && frame.block_start) begin
				for (int i = 0; i < MAX_CHANNELS; i++) begin
					env_q[i] <= combined_q;
				end
			end else if (cmd.env_b) begin
				env_q[ch] <= env_new;
			end
			if (cmd.gain_eval) begin
				combined_q <= peak_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			frame_q <= frame;
			peak_q  <= '0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				res_q[i] <= '0;
			end
		end else begin
			if (cmd.env_b && (env_new > peak_q)) begin
				peak_q <= env_new;
			end
			if (cmd.out_mul) begin
				res_q[ch] <= res_val;
			end
		end
		if (cmd.env_a) begin
			mag_s1  <= mag_sat;
			diff_s1 <= rise ? (mag_sat - env_cur) : (env_cur - mag_sat);
			rise_s1 <= rise;
			coef_s1 <= rise ? attack_q : release_q;
		end
		if (cmd.set_unity) begin
			gain_q <= apl_pkg::UNITY_GAIN;
		end else if (cmd.take_quot) begin
			gain_q <= {1'b0, quot};
		end
		if (cmd.publish) begin
			result_q <= apl_pkg::pack_result(outs_all, gain_q, combined_q);
		end
	end

	apl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (threshold_q),
		.divisor  (peak_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quot)
	);

	always_comb begin
		sts.n_zero   = (n_ch == '0);
		sts.last_ch  = (CNT_W'(ch) == (n_ch - CNT_W'(1)));
		sts.need_div = peak_q > threshold_q;
		sts.div_busy = div_busy;
		sts.div_done = div_done;
	end

	assign result = result_q;

endmodule

@@ design/apl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apl_ctrl - limiter sequencer
// Walks one frame through envelope update, gain calculation and output
// scaling, and owns both handshakes and the channel counter.
// ----------------------------------------------------------------------------
module apl_ctrl #(
	parameter int CH_W = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frame_valid,
	output logic                frame_stall,
	output logic                result_valid,
	input  logic                result_stall,
	input  apl_pkg::ctrl_sts_t  sts,
	output apl_pkg::ctrl_cmd_t  cmd,
	output logic [CH_W-1:0]     ch
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENV_A,
		S_ENV_B,
		S_GAIN,
		S_DIV,
		S_OUT,
		S_DONE
	} state_t;

	state_t          state_q;
	state_t          state_d;
	logic [CH_W-1:0] ch_q;
	logic [CH_W-1:0] ch_d;
	logic            result_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		ch_d    = ch_q;
		unique case (state_q)
			S_IDLE: begin
				if (frame_valid) begin
					cmd.capture = 1'b1;
					ch_d        = '0;
					state_d     = sts.n_zero ? S_GAIN : S_ENV_A;
				end
			end
			S_ENV_A: begin
				cmd.env_a = 1'b1;
				state_d   = S_ENV_B;
			end
			S_ENV_B: begin
				cmd.env_b = 1'b1;
				if (sts.last_ch) begin
					state_d = S_GAIN;
				end else begin
					ch_d    = ch_q + CH_W'(1);
					state_d = S_ENV_A;
				end
			end
			S_GAIN: begin
				cmd.gain_eval = 1'b1;
				ch_d          = '0;
				if (sts.need_div) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					cmd.set_unity = 1'b1;
					state_d       = sts.n_zero ? S_DONE : S_OUT;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.take_quot = 1'b1;
					state_d       = S_OUT;
				end
			end
			S_OUT: begin
				cmd.out_mul = 1'b1;
				if (sts.last_ch) begin
					state_d = S_DONE;
				end else begin
					ch_d = ch_q + CH_W'(1);
				end
			end
			S_DONE: begin
				// The result register frees up in the same cycle its beat is taken.
				if (!result_valid_q || !result_stall) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ch_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
			if (cmd.publish) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign frame_stall  = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign ch           = ch_q;

endmodule

@@ design/audio_peak_limiter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_peak_limiter_core - feedforward peak limiter for multichannel frames
// Per-channel peak envelopes, a combined envelope, a threshold/envelope gain
// and a gain applied to every sample in use.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------
//   frame    | frame_valid / frame_stall | frame   (8 samples, block_start)
//   result   | result_valid/result_stall | result  (8 outs, gain, envelope)
//   config   | cfg_we                    | cfg_index, cfg_data
//
// Each frame is captured, each channel in use gets its envelope update, the
// gain step follows, and each channel is then scaled; over threshold the
// 23-step restoring divider runs before the scaling. The shared envelope
// multiplier serves a channel in the ENV_A and ENV_B states, the output
// multiplier in the OUT state. A new frame is taken in the cycle after its
// predecessor reaches the result register; a stalled result holds only the
// final hand-over. Reset clears envelopes, registers take their defaults.
// ----------------------------------------------------------------------------
module audio_peak_limiter_core #(
	parameter int MAX_CHANNELS = apl_pkg::DEF_MAX_CHANNELS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [apl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [apl_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            frame_valid,
	output logic                            frame_stall,
	input  apl_pkg::frame_t                 frame,
	output logic                            result_valid,
	input  logic                            result_stall,
	output apl_pkg::result_t                result
);

	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	apl_pkg::ctrl_cmd_t  cmd;
	apl_pkg::ctrl_sts_t  sts;
	logic [CH_W-1:0]     ch;

	apl_ctrl #(
		.CH_W (CH_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd),
		.ch           (ch)
	);

	apl_dp #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.CH_W         (CH_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.frame     (frame),
		.ch        (ch),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

`ifndef NO_ASSERTIONS
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && !frame_stall) |=> frame_stall)
		else $error("frame taken while the previous one is still in work");

	a_stall_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> frame_stall)
		else $error("input open while the gain divider runs");

	a_gain_at_most_unity: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.applied_gain <= apl_pkg::UNITY_GAIN))
		else $error("applied gain above unity");

	a_silent_unity: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.peak_envelope == '0)) |->
		(result.applied_gain == apl_pkg::UNITY_GAIN))
		else $error("gain reduced with a zero envelope");
`endif

endmodule

@@ tb/sv/audio_peak_limiter_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_peak_limiter_core_tb - self-checking bench for the peak limiter core
// Frames are driven from a queue and every frame beat is run through a local
// model of the envelope followers, the threshold divider and the output
// gain. Each result beat is compared field by field with the oldest
// prediction. A short directed sequence exercises full-scale samples, block
// starts and the odd channel counts. Random phases with changing register
// settings and changing idle patterns on both channels then follow.
// ----------------------------------------------------------------------------
module audio_peak_limiter_core_tb;

	localparam int PHASES_PER_MODE = 5;
	localparam int PHASE_FRAMES    = 115;
	localparam int LONG_HOLD       = 400;
	localparam int SETTLE_CYCLES   = 60;

	localparam apl_pkg::sample_t FULL_POS = {1'b0, {(apl_pkg::SMP_W-1){1'b1}}};
	localparam apl_pkg::sample_t FULL_NEG = {1'b1, {(apl_pkg::SMP_W-1){1'b0}}};

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          cfg_we       = 1'b0;
	logic [apl_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
	logic [apl_pkg::CFG_W-1:0]     cfg_data     = '0;
	logic                          frame_valid  = 1'b0;
	logic                          frame_stall;
	apl_pkg::frame_t               frame        = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	apl_pkg::result_t              result;

	// Limiter model: register copies and envelope state.
	apl_pkg::env_t                lim_thr = apl_pkg::THRESHOLD_RST;
	logic [apl_pkg::COEF_W-1:0]   lim_atk = apl_pkg::ATTACK_RST;
	logic [apl_pkg::COEF_W-1:0]   lim_rel = apl_pkg::RELEASE_RST;
	logic [apl_pkg::CHCFG_W-1:0]  lim_nch = apl_pkg::CHANNELS_RST;
	apl_pkg::env_t                chan_env [apl_pkg::NUM_LANES];
	apl_pkg::env_t                comb_env = '0;

	apl_pkg::frame_t   pending_frames [$];
	apl_pkg::result_t  limited_due [$];
	logic              frame_taken = 1'b0;
	int unsigned       tx_idle_pct = 0;
	int unsigned       rx_idle_pct = 0;
	logic              hold_req    = 1'b0;
	logic              hold_seen   = 1'b0;
	int unsigned       hold_left   = 0;
	int unsigned       fail_cnt    = 0;

	audio_peak_limiter_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.frame        (frame),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic apl_pkg::sample_t frame_lane(apl_pkg::frame_t f, int c);
		case (c)
		0: return f.sample_0;
		1: return f.sample_1;
		2: return f.sample_2;
		3: return f.sample_3;
		4: return f.sample_4;
		5: return f.sample_5;
		6: return f.sample_6;
		default: return f.sample_7;
		endcase
	endfunction

	function automatic apl_pkg::sample_t result_lane(apl_pkg::result_t r, int c);
		case (c)
		0: return r.out_0;
		1: return r.out_1;
		2: return r.out_2;
		3: return r.out_3;
		4: return r.out_4;
		5: return r.out_5;
		6: return r.out_6;
		default: return r.out_7;
		endcase
	endfunction

	// One follower step; the correction is truncated towards the magnitude.
	function automatic apl_pkg::env_t follow_env(apl_pkg::env_t e, longint mag);
		longint ev;
		longint corr;
		ev = e;
		if (ev < mag) begin
			corr = (longint'(lim_atk) * (mag - ev)) >>> 16;
			return apl_pkg::env_t'(mag - corr);
		end
		corr = (longint'(lim_rel) * (ev - mag)) >>> 16;
		return apl_pkg::env_t'(mag + corr);
	endfunction

	function automatic apl_pkg::result_t limit_frame(apl_pkg::frame_t f);
		apl_pkg::result_t r;
		apl_pkg::sample_t outs [apl_pkg::NUM_LANES];
		int               n;
		longint           s;
		longint           mag;
		longint           prod;
		longint           gain;
		apl_pkg::env_t    peak;
		n = (lim_nch > apl_pkg::NUM_LANES) ? apl_pkg::NUM_LANES : int'(lim_nch);
		if (f.block_start) begin
			for (int c = 0; c < apl_pkg::NUM_LANES; c++) chan_env[c] = comb_env;
		end
		peak = '0;
		for (int c = 0; c < n; c++) begin
			s = frame_lane(f, c);
			mag = (s < 0) ? -s : s;
			if (mag > longint'(apl_pkg::ENV_MAX)) mag = longint'(apl_pkg::ENV_MAX);
			chan_env[c] = follow_env(chan_env[c], mag);
			if (chan_env[c] > peak) peak = chan_env[c];
		end
		comb_env = peak;
		if (peak > lim_thr) gain = (longint'(lim_thr) << 23) / longint'(peak);
		else gain = longint'(apl_pkg::UNITY_GAIN);
		for (int c = 0; c < apl_pkg::NUM_LANES; c++) begin
			outs[c] = '0;
			if (c < n) begin
				s = frame_lane(f, c);
				mag = (s < 0) ? -s : s;
				prod = (mag * gain) >>> 23;
				outs[c] = apl_pkg::sample_t'((s < 0) ? -prod : prod);
			end
		end
		r.out_0         = outs[0];
		r.out_1         = outs[1];
		r.out_2         = outs[2];
		r.out_3         = outs[3];
		r.out_4         = outs[4];
		r.out_5         = outs[5];
		r.out_6         = outs[6];
		r.out_7         = outs[7];
		r.applied_gain  = apl_pkg::gain_t'(gain);
		r.peak_envelope = peak;
		return r;
	endfunction

	task automatic check_result(apl_pkg::result_t got);
		apl_pkg::result_t want;
		if (limited_due.size() == 0) begin
			$error("result beat with no frame outstanding: %h", got);
			fail_cnt++;
			return;
		end
		want = limited_due.pop_front();
		for (int c = 0; c < apl_pkg::NUM_LANES; c++) begin
			if (result_lane(got, c) !== result_lane(want, c)) begin
				$error("out_%0d: expected %0d, got %0d", c, result_lane(want, c),
					result_lane(got, c));
				fail_cnt++;
			end
		end
		if (got.applied_gain !== want.applied_gain) begin
			$error("applied_gain: expected %0d, got %0d", want.applied_gain,
				got.applied_gain);
			fail_cnt++;
		end
		if (got.peak_envelope !== want.peak_envelope) begin
			$error("peak_envelope: expected %0d, got %0d", want.peak_envelope,
				got.peak_envelope);
			fail_cnt++;
		end
	endtask

	// Frame driver: a beat is held until the edge that takes it.
	always @(negedge clk) begin
		if (!frame_valid || frame_taken) begin
			if (pending_frames.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				frame       <= pending_frames.pop_front();
				frame_valid <= 1'b1;
			end else begin
				frame_valid <= 1'b0;
			end
		end
	end

	// Result sink: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen    <= hold_req;
			hold_left    <= LONG_HOLD;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		frame_taken <= frame_valid && !frame_stall;
		if (arst_n) begin
			if (frame_valid && !frame_stall) limited_due.push_back(limit_frame(frame));
			if (result_valid && !result_stall) check_result(result);
		end
	end

	task automatic write_reg(logic [apl_pkg::CFG_IDX_W-1:0] idx,
		logic [apl_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
		apl_pkg::REG_THRESHOLD: lim_thr = val[apl_pkg::ENV_W-1:0];
		apl_pkg::REG_ATTACK:    lim_atk = val[apl_pkg::COEF_W-1:0];
		apl_pkg::REG_RELEASE:   lim_rel = val[apl_pkg::COEF_W-1:0];
		apl_pkg::REG_CHANNELS:  lim_nch = val[apl_pkg::CHCFG_W-1:0];
		default:                ;
		endcase
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_frames.size() != 0 || frame_valid || limited_due.size() != 0);
	endtask

	function automatic apl_pkg::frame_t uniform_frame(apl_pkg::sample_t even,
		apl_pkg::sample_t odd, logic bs);
		apl_pkg::frame_t f;
		f.sample_0    = even;
		f.sample_1    = odd;
		f.sample_2    = even;
		f.sample_3    = odd;
		f.sample_4    = even;
		f.sample_5    = odd;
		f.sample_6    = even;
		f.sample_7    = odd;
		f.block_start = bs;
		return f;
	endfunction

	function automatic apl_pkg::sample_t pick_sample(int unsigned shift);
		apl_pkg::sample_t s;
		int unsigned      r;
		r = $urandom_range(99);
		s = apl_pkg::sample_t'($urandom);
		if (r < 3) s = FULL_NEG;
		else if (r < 6) s = FULL_POS;
		else if (r < 8) s = '0;
		else s = s >>> shift;
		return s;
	endfunction

	function automatic apl_pkg::frame_t random_frame(int unsigned shift);
		apl_pkg::frame_t f;
		f.sample_0    = pick_sample(shift);
		f.sample_1    = pick_sample(shift);
		f.sample_2    = pick_sample(shift);
		f.sample_3    = pick_sample(shift);
		f.sample_4    = pick_sample(shift);
		f.sample_5    = pick_sample(shift);
		f.sample_6    = pick_sample(shift);
		f.sample_7    = pick_sample(shift);
		f.block_start = ($urandom_range(99) < 6);
		return f;
	endfunction

	// New settings, then a run of frames in bursts of one loudness each.
	task automatic load_random_phase(int unsigned count);
		logic [apl_pkg::CFG_W-1:0] thr;
		logic [apl_pkg::CFG_W-1:0] atk;
		logic [apl_pkg::CFG_W-1:0] rel;
		logic [apl_pkg::CFG_W-1:0] nch;
		int unsigned               shift;
		case ($urandom_range(5))
		0:       thr = '0;
		1:       thr = apl_pkg::ENV_MAX;
		default: thr = apl_pkg::CFG_W'($urandom_range(apl_pkg::ENV_MAX, 1 << 18));
		endcase
		case ($urandom_range(4))
		0:       atk = '0;
		1:       atk = apl_pkg::CFG_W'(16'hFFFF);
		default: atk = apl_pkg::CFG_W'($urandom_range(16'hFFFF));
		endcase
		case ($urandom_range(4))
		0:       rel = '0;
		1:       rel = apl_pkg::CFG_W'(16'hFFFF);
		default: rel = apl_pkg::CFG_W'($urandom_range(16'hFFFF, 60000));
		endcase
		case ($urandom_range(9))
		0:       nch = '0;
		1:       nch = apl_pkg::CFG_W'(1);
		2:       nch = apl_pkg::CFG_W'(apl_pkg::NUM_LANES);
		3:       nch = apl_pkg::CFG_W'($urandom_range(15, apl_pkg::NUM_LANES + 1));
		default: nch = apl_pkg::CFG_W'($urandom_range(apl_pkg::NUM_LANES, 1));
		endcase
		write_reg(apl_pkg::REG_THRESHOLD, thr);
		write_reg(apl_pkg::REG_ATTACK, atk);
		write_reg(apl_pkg::REG_RELEASE, rel);
		write_reg(apl_pkg::REG_CHANNELS, nch);
		shift = 0;
		for (int i = 0; i < count; i++) begin
			if (i % 16 == 0) begin
				case ($urandom_range(7))
				0, 1:    shift = 0;
				2:       shift = 1;
				3:       shift = 2;
				4:       shift = 4;
				5:       shift = 8;
				6:       shift = 14;
				default: shift = 20;
				endcase
			end
			pending_frames.push_back(random_frame(shift));
		end
	endtask

	initial begin
		for (int c = 0; c < apl_pkg::NUM_LANES; c++) chan_env[c] = '0;
		tx_idle_pct = 13;
		rx_idle_pct = 67;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings, two channels in use; the other lanes must read zero.
		pending_frames.push_back(uniform_frame('0, '0, 1'b0));
		pending_frames.push_back(uniform_frame(FULL_POS, FULL_NEG, 1'b0));
		pending_frames.push_back(uniform_frame(FULL_POS, FULL_NEG, 1'b0));
		pending_frames.push_back(uniform_frame(FULL_NEG, FULL_NEG, 1'b0));
		pending_frames.push_back(uniform_frame('0, '0, 1'b0));
		pending_frames.push_back(uniform_frame(apl_pkg::sample_t'(1000),
			-apl_pkg::sample_t'(1000), 1'b1));
		pending_frames.push_back(uniform_frame(-apl_pkg::sample_t'(1),
			apl_pkg::sample_t'(1), 1'b0));
		drain();

		write_reg(apl_pkg::REG_CHANNELS, apl_pkg::CFG_W'(apl_pkg::NUM_LANES));
		pending_frames.push_back(uniform_frame(FULL_POS, FULL_POS, 1'b0));
		pending_frames.push_back(uniform_frame(FULL_NEG, FULL_NEG, 1'b0));
		pending_frames.push_back(uniform_frame(FULL_POS, FULL_NEG, 1'b0));
		pending_frames.push_back(uniform_frame('0, '0, 1'b1));
		drain();

		// No channel in use, then a count beyond the lane count.
		write_reg(apl_pkg::REG_CHANNELS, '0);
		pending_frames.push_back(random_frame(0));
		pending_frames.push_back(uniform_frame(FULL_POS, FULL_NEG, 1'b1));
		drain();
		write_reg(apl_pkg::REG_CHANNELS, apl_pkg::CFG_W'(15));
		pending_frames.push_back(random_frame(0));
		pending_frames.push_back(random_frame(0));
		drain();

		write_reg(apl_pkg::REG_THRESHOLD, '0);
		write_reg(apl_pkg::REG_ATTACK, '0);
		write_reg(apl_pkg::REG_RELEASE, '0);
		write_reg(apl_pkg::REG_CHANNELS, apl_pkg::CFG_W'(4));
		for (int i = 0; i < 3; i++) pending_frames.push_back(random_frame(0));
		drain();

		write_reg(apl_pkg::REG_THRESHOLD, apl_pkg::ENV_MAX);
		write_reg(apl_pkg::REG_ATTACK, apl_pkg::CFG_W'(16'hFFFF));
		write_reg(apl_pkg::REG_RELEASE, apl_pkg::CFG_W'(16'hFFFF));
		write_reg(apl_pkg::REG_CHANNELS, apl_pkg::CFG_W'(apl_pkg::NUM_LANES));
		for (int i = 0; i < 3; i++) pending_frames.push_back(random_frame(0));
		pending_frames.push_back(uniform_frame(FULL_NEG, FULL_NEG, 1'b0));
		drain();

		for (int m = 0; m < 3; m++) begin
			case (m)
			0: begin
				tx_idle_pct = 13;
				rx_idle_pct = 67;
			end
			1: begin
				tx_idle_pct = 67;
				rx_idle_pct = 13;
			end
			default: begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			endcase
			for (int p = 0; p < PHASES_PER_MODE; p++) begin
				load_random_phase(PHASE_FRAMES);
				// The sink holds off while frames keep coming, so the core backs up.
				if (m == 2 && p == 0) hold_req = ~hold_req;
				drain();
			end
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("audio_peak_limiter_core_tb: done, clean");
		end else begin
			$display("audio_peak_limiter_core_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("audio_peak_limiter_core_tb: done, errors");
		$finish;
	end

endmodule
